[rtl/p2c_pkg.sv]
// ----------------------------------------------------------------------------
// p2c_pkg
// Shared constants and types of the packed 2-bit-per-pixel column engine.
// ----------------------------------------------------------------------------
package p2c_pkg;

  localparam int STORE_BYTES = 16384;
  localparam int MAX_RUN     = 32;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int IDX_W       = $clog2(MAX_RUN);

  localparam int COORD_W  = 16;
  localparam int LIMIT_W  = 15;
  localparam int STRIDE_W = 14;
  localparam int COLOR_W  = 2;
  localparam int RUN_W    = 6;
  localparam int DATA_W   = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [7:0] PIX_MASK  = 8'h03;
  localparam logic [7:0] BYTE_MASK = 8'hff;

  typedef enum logic [1:0] {
    OP_FILL = 2'd0,
    OP_PUT  = 2'd1,
    OP_GET  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP_LEFT      = 3'd0,
    REG_CLIP_TOP       = 3'd1,
    REG_CLIP_RIGHT     = 3'd2,
    REG_CLIP_BOTTOM    = 3'd3,
    REG_VIRTUAL_WIDTH  = 3'd4,
    REG_VIRTUAL_HEIGHT = 3'd5,
    REG_ROW_STRIDE     = 3'd6,
    REG_FG_COLOR       = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLIP,
    ST_ADDR,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

[rtl/p2c_if.sv]
// ----------------------------------------------------------------------------
// p2c_if
// Valid/ready channels of the column engine: command items in, result items out.
// ----------------------------------------------------------------------------
interface p2c_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic signed [15:0]            column;
  logic signed [15:0]            start_row;
  logic [p2c_pkg::RUN_W-1:0]     run_height;
  logic [p2c_pkg::DATA_W-1:0]    pixel_data;

  modport source (output valid, operation, column, start_row, run_height, pixel_data,
                  input ready);
  modport sink (input valid, operation, column, start_row, run_height, pixel_data,
                output ready);
endinterface

interface p2c_out_if;
  logic                          valid;
  logic                          ready;
  logic [p2c_pkg::DATA_W-1:0]    packed_result;
  logic [p2c_pkg::RUN_W-1:0]     pixels_done;

  modport source (output valid, packed_result, pixels_done, input ready);
  modport sink (input valid, packed_result, pixels_done, output ready);
endinterface

[rtl/p2c_store.sv]
// ----------------------------------------------------------------------------
// p2c_store
// Byte-wide frame store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module p2c_store (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [p2c_pkg::AW-1:0] wr_addr,
  input  logic [7:0]             wr_data,
  input  logic [p2c_pkg::AW-1:0] rd_addr,
  output logic [7:0]             rd_data_r
);

  logic [7:0] mem [p2c_pkg::STORE_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

[rtl/packed_2bpp_column_engine.sv]
// ----------------------------------------------------------------------------
// packed_2bpp_column_engine
// Fill, put and get of vertical pixel runs in a packed 2-bit-per-pixel store.
// ----------------------------------------------------------------------------
// After reset the engine clears all STORE_BYTES (16384) bytes of the frame
// store, one byte per cycle, and takes no item until that is done;
// configuration writes are taken throughout. An item covers at most 32 rows
// after clipping: the store's single read and write ports carry one
// read-modify-write per row for fill and put and one read per row for get,
// pipelined one row per cycle with forwarding of the byte just written. An
// item that is clipped away or has the unused operation code goes from
// clipping straight to its result. One item is in work at a time; a finished
// result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module packed_2bpp_column_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  p2c_in_if.sink                            in_ch,
  p2c_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [p2c_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [p2c_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW    = p2c_pkg::AW;
  localparam int IDX_W = p2c_pkg::IDX_W;

  // Configuration registers.
  logic [p2c_pkg::LIMIT_W-1:0]  clip_left_r, clip_top_r, clip_right_r, clip_bottom_r;
  logic [p2c_pkg::LIMIT_W-1:0]  virtual_width_r, virtual_height_r;
  logic [p2c_pkg::STRIDE_W-1:0] row_stride_r;
  logic [p2c_pkg::COLOR_W-1:0]  fg_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r      <= '0;
      clip_top_r       <= '0;
      clip_right_r     <= 15'd256;
      clip_bottom_r    <= 15'd256;
      virtual_width_r  <= 15'd256;
      virtual_height_r <= 15'd256;
      row_stride_r     <= 14'd64;
      fg_color_r       <= 2'd3;
    end else if (cfg_we) begin
      unique case (p2c_pkg::cfg_reg_t'(cfg_index))
        p2c_pkg::REG_CLIP_LEFT:      clip_left_r      <= cfg_data;
        p2c_pkg::REG_CLIP_TOP:       clip_top_r       <= cfg_data;
        p2c_pkg::REG_CLIP_RIGHT:     clip_right_r     <= cfg_data;
        p2c_pkg::REG_CLIP_BOTTOM:    clip_bottom_r    <= cfg_data;
        p2c_pkg::REG_VIRTUAL_WIDTH:  virtual_width_r  <= cfg_data;
        p2c_pkg::REG_VIRTUAL_HEIGHT: virtual_height_r <= cfg_data;
        p2c_pkg::REG_ROW_STRIDE:     row_stride_r     <= cfg_data[p2c_pkg::STRIDE_W-1:0];
        p2c_pkg::REG_FG_COLOR:       fg_color_r       <= cfg_data[p2c_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // State machine.
  p2c_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]      clr_addr_r;
  logic               clr_last;
  logic [p2c_pkg::RUN_W-1:0] rem_r;
  logic               empty;
  logic               in_ready;
  logic               issue_rd;
  logic               load_out;
  logic               clr_active;
  logic               out_valid_r;

  assign clr_last = (clr_addr_r == AW'(p2c_pkg::STORE_BYTES - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      p2c_pkg::ST_CLEAR: if (clr_last) state_nxt = p2c_pkg::ST_IDLE;
      p2c_pkg::ST_IDLE:  if (in_ch.valid) state_nxt = p2c_pkg::ST_CLIP;
      p2c_pkg::ST_CLIP:  state_nxt = empty ? p2c_pkg::ST_DONE : p2c_pkg::ST_ADDR;
      p2c_pkg::ST_ADDR:  state_nxt = p2c_pkg::ST_RUN;
      p2c_pkg::ST_RUN:   if (rem_r == p2c_pkg::RUN_W'(1)) state_nxt = p2c_pkg::ST_DRAIN;
      p2c_pkg::ST_DRAIN: state_nxt = p2c_pkg::ST_DONE;
      p2c_pkg::ST_DONE:  if (!out_valid_r || out_ch.ready) state_nxt = p2c_pkg::ST_IDLE;
      default:           state_nxt = p2c_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    issue_rd   = 1'b0;
    load_out   = 1'b0;
    clr_active = 1'b0;
    unique case (state_r)
      p2c_pkg::ST_CLEAR: clr_active = 1'b1;
      p2c_pkg::ST_IDLE:  in_ready = 1'b1;
      p2c_pkg::ST_RUN:   issue_rd = 1'b1;
      p2c_pkg::ST_DONE:  load_out = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= p2c_pkg::ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_active) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  assign in_ch.ready = in_ready;

  // Captured command.
  logic [1:0]                   op_r;
  logic signed [15:0]           x_r, y_r;
  logic [p2c_pkg::RUN_W-1:0]    h_r;
  logic [p2c_pkg::DATA_W-1:0]   data_r;

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      op_r   <= in_ch.operation;
      x_r    <= in_ch.column;
      y_r    <= in_ch.start_row;
      h_r    <= in_ch.run_height;
      data_r <= in_ch.pixel_data;
    end
  end

  // Clipping.
  logic                       is_get;
  logic [p2c_pkg::RUN_W-1:0]  h_cl;
  logic signed [17:0]         xs, ys, lft, tp, rgt, bot, skip, ycl, hrem;

  assign is_get = (p2c_pkg::op_t'(op_r) == p2c_pkg::OP_GET);

  always_comb begin
    h_cl = (h_r > p2c_pkg::RUN_W'(p2c_pkg::MAX_RUN)) ? p2c_pkg::RUN_W'(p2c_pkg::MAX_RUN) : h_r;
    xs   = {{2{x_r[15]}}, x_r};
    ys   = {{2{y_r[15]}}, y_r};
    if (is_get) begin
      lft = '0;
      tp  = '0;
      rgt = {3'b000, virtual_width_r};
      bot = {3'b000, virtual_height_r};
    end else begin
      lft = {3'b000, clip_left_r};
      tp  = {3'b000, clip_top_r};
      rgt = {3'b000, clip_right_r};
      bot = {3'b000, clip_bottom_r};
    end
    if (ys < tp) begin
      skip = tp - ys;
      ycl  = tp;
    end else begin
      skip = '0;
      ycl  = ys;
    end
    hrem = {12'd0, h_cl} - skip;
    if (ycl + hrem > bot) begin
      hrem = bot - ycl;
    end
    empty = (p2c_pkg::op_t'(op_r) == p2c_pkg::OP_NONE) || (xs < lft) || (xs >= rgt)
            || (hrem <= 18'sd0);
  end

  logic [p2c_pkg::LIMIT_W-1:0] ycl_r;
  logic [IDX_W-1:0]            idx_r;
  logic [p2c_pkg::RUN_W-1:0]   done_cnt_r;
  logic [AW-1:0]               addr_r;
  logic [28:0]                 prod;

  assign prod = ycl_r * row_stride_r;

  always_ff @(posedge clk) begin
    if (state_r == p2c_pkg::ST_CLIP) begin
      ycl_r      <= ycl[p2c_pkg::LIMIT_W-1:0];
      idx_r      <= skip[IDX_W-1:0];
      done_cnt_r <= empty ? '0 : hrem[p2c_pkg::RUN_W-1:0];
      rem_r      <= hrem[p2c_pkg::RUN_W-1:0];
    end else if (issue_rd) begin
      idx_r  <= idx_r + IDX_W'(1);
      rem_r  <= rem_r - p2c_pkg::RUN_W'(1);
    end
    if (state_r == p2c_pkg::ST_ADDR) begin
      addr_r <= AW'(prod) + AW'(x_r[14:2]);
    end else if (issue_rd) begin
      addr_r <= addr_r + AW'(row_stride_r);
    end
  end

  // Read stage and modify/write stage.
  logic              p1_valid_r;
  logic [AW-1:0]     p1_addr_r;
  logic [IDX_W-1:0]  p1_idx_r;
  logic              wr_valid_r;
  logic [AW-1:0]     wr_addr_r;
  logic [7:0]        wr_data_r;
  logic [7:0]        rd_q;
  logic [7:0]        byte_cur;
  logic [7:0]        byte_new;
  logic [7:0]        pix_mask;
  logic [2:0]        pix_sh;
  logic [1:0]        pix_new;
  logic [1:0]        pix_rd;
  logic [IDX_W:0]    bitpos;
  logic              row_wr;
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [7:0]        st_wdata;

  always_comb begin
    pix_sh   = {x_r[1:0], 1'b0};
    bitpos   = {p1_idx_r, 1'b0};
    byte_cur = (wr_valid_r && (wr_addr_r == p1_addr_r)) ? wr_data_r : rd_q;
    pix_rd   = byte_cur[pix_sh +: 2];
    pix_new  = (p2c_pkg::op_t'(op_r) == p2c_pkg::OP_FILL) ? fg_color_r : data_r[bitpos +: 2];
    pix_mask = (p2c_pkg::PIX_MASK << pix_sh) & p2c_pkg::BYTE_MASK;
    byte_new = (byte_cur & ~pix_mask) | ({6'd0, pix_new} << pix_sh);
    row_wr   = p1_valid_r && !is_get;
    if (clr_active) begin
      st_we    = 1'b1;
      st_waddr = clr_addr_r;
      st_wdata = '0;
    end else begin
      st_we    = row_wr;
      st_waddr = p1_addr_r;
      st_wdata = byte_new;
    end
  end

  p2c_store u_store (
    .clk       (clk),
    .wr_en     (st_we),
    .wr_addr   (st_waddr),
    .wr_data   (st_wdata),
    .rd_addr   (addr_r),
    .rd_data_r (rd_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      wr_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= issue_rd;
      wr_valid_r <= row_wr;
    end
  end

  always_ff @(posedge clk) begin
    p1_addr_r <= addr_r;
    p1_idx_r  <= idx_r;
    wr_addr_r <= p1_addr_r;
    wr_data_r <= byte_new;
  end

  logic [p2c_pkg::DATA_W-1:0] res_r;

  always_ff @(posedge clk) begin
    if (state_r == p2c_pkg::ST_CLIP) begin
      res_r <= is_get ? data_r : '0;
    end else if (p1_valid_r && is_get) begin
      res_r[bitpos +: 2] <= pix_rd;
    end
  end

  // Output register.
  logic [p2c_pkg::DATA_W-1:0] out_result_r;
  logic [p2c_pkg::RUN_W-1:0]  out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_result_r <= res_r;
      out_done_r   <= done_cnt_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.packed_result = out_result_r;
  assign out_ch.pixels_done   = out_done_r;

endmodule
